// File: design/sfd_pkg.sv
// sfd_pkg: constants and crc helper for the sensor frame deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND = 8'h55;

    // payload byte positions within a frame
    localparam logic [2:0] IDX_SEQ    = 3'd0;
    localparam logic [2:0] IDX_TEMP0  = 3'd1;
    localparam logic [2:0] IDX_TEMP1  = 3'd2;
    localparam logic [2:0] IDX_TEMP2  = 3'd3;
    localparam logic [2:0] IDX_TEMP3  = 3'd4;
    localparam logic [2:0] IDX_CRC_LO = 3'd5;
    localparam logic [2:0] IDX_CRC_HI = 3'd6;

    localparam logic [2:0] CRC_SPAN = 3'd5;

    // crc-16/ccitt-false, one byte msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/sensor_frame_deframer_crc16.sv
// sensor_frame_deframer_crc16: sync-word hunt, frame collection and crc check
// depends on sfd_pkg
`timescale 1ns / 1ps
`default_nettype none

//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | rx_byte
//  out     | out_valid / out_ready| crc_ok, frame_seq, temp_bits, drop_count,
//          |                      | link_up
//
// one byte per cycle; a stalled output holds back only the byte that ends a
// frame; other bytes keep flowing. a byte is held in the input register, then
// the crc step (eight unrolled shifts) and frame state update run from it into
// the frame state registers, and the result register takes a frame's result
// as its last byte leaves. rst_n clears all frame and link state at once.

module sensor_frame_deframer_crc16 (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             crc_ok,
    output logic [7:0]       frame_seq,
    output logic [31:0]      temp_bits,
    output logic [7:0]       drop_count,
    output logic             link_up
);
    import sfd_pkg::*;

    logic        s1_vld_reg;
    logic [7:0]  s1_byte_reg;

    logic [7:0]  prev_reg,   prev_next;
    logic [2:0]  cnt_reg,    cnt_next;
    logic        frame_reg,  frame_next;
    logic [15:0] crc_reg,    crc_next;
    logic [7:0]  seq_reg,    seq_next;
    logic [31:0] ftemp_reg,  ftemp_next;
    logic [7:0]  rcrc_lo_reg, rcrc_lo_next;
    logic [7:0]  exp_reg,    exp_next;
    logic [7:0]  miss_reg,   miss_next;
    logic [31:0] stemp_reg,  stemp_next;
    logic        link_reg,   link_next;

    logic        ovld_reg;
    logic        ok_reg;
    logic [7:0]  oseq_reg;
    logic [31:0] otemp_reg;
    logic [7:0]  odrop_reg;
    logic        olink_reg;

    logic        ends_frame;
    logic        out_free;
    logic        advance;
    logic        ok;

    assign ends_frame = frame_reg && (cnt_reg == IDX_CRC_HI);
    assign out_free   = !ovld_reg || out_ready;
    assign advance    = s1_vld_reg && (!ends_frame || out_free);
    assign in_ready   = !s1_vld_reg || advance;
    assign ok         = ({s1_byte_reg, rcrc_lo_reg} == crc_reg);

    always_comb
    begin
        prev_next    = prev_reg;
        cnt_next     = cnt_reg;
        frame_next   = frame_reg;
        crc_next     = crc_reg;
        seq_next     = seq_reg;
        ftemp_next   = ftemp_reg;
        rcrc_lo_next = rcrc_lo_reg;
        exp_next     = exp_reg;
        miss_next    = miss_reg;
        stemp_next   = stemp_reg;
        link_next    = link_reg;
        if (!frame_reg)
        begin
            if (prev_reg == SYNC_FIRST && s1_byte_reg == SYNC_SECOND)
            begin
                frame_next   = 1'b1;
                cnt_next     = IDX_SEQ;
                crc_next     = CRC_INIT;
                ftemp_next   = '0;
                rcrc_lo_next = '0;
            end
            else
            begin
                prev_next = s1_byte_reg;
            end
        end
        else
        begin
            if (cnt_reg < CRC_SPAN)
            begin
                crc_next = crc_byte(crc_reg, s1_byte_reg);
            end
            case (cnt_reg)
                IDX_SEQ:    seq_next           = s1_byte_reg;
                IDX_TEMP0:  ftemp_next[7:0]    = s1_byte_reg;
                IDX_TEMP1:  ftemp_next[15:8]   = s1_byte_reg;
                IDX_TEMP2:  ftemp_next[23:16]  = s1_byte_reg;
                IDX_TEMP3:  ftemp_next[31:24]  = s1_byte_reg;
                IDX_CRC_LO: rcrc_lo_next       = s1_byte_reg;
                default:    rcrc_lo_next       = rcrc_lo_reg;
            endcase
            if (cnt_reg != IDX_CRC_HI)
            begin
                cnt_next = cnt_reg + 3'd1;
            end
            else
            begin
                if (ok)
                begin
                    stemp_next = ftemp_reg;
                    miss_next  = miss_reg + (seq_reg - exp_reg);
                    link_next  = 1'b1;
                    exp_next   = seq_reg + 8'd1;
                end
                frame_next = 1'b0;
                cnt_next   = IDX_SEQ;
                prev_next  = '0;
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '0;
            cnt_reg     <= '0;
            frame_reg   <= 1'b0;
            crc_reg     <= CRC_INIT;
            seq_reg     <= '0;
            ftemp_reg   <= '0;
            rcrc_lo_reg <= '0;
            exp_reg     <= '0;
            miss_reg    <= '0;
            stemp_reg   <= '0;
            link_reg    <= 1'b0;
        end
        else if (advance)
        begin
            prev_reg    <= prev_next;
            cnt_reg     <= cnt_next;
            frame_reg   <= frame_next;
            crc_reg     <= crc_next;
            seq_reg     <= seq_next;
            ftemp_reg   <= ftemp_next;
            rcrc_lo_reg <= rcrc_lo_next;
            exp_reg     <= exp_next;
            miss_reg    <= miss_next;
            stemp_reg   <= stemp_next;
            link_reg    <= link_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            ovld_reg <= advance && ends_frame;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && ends_frame)
        begin
            ok_reg    <= ok;
            oseq_reg  <= seq_reg;
            otemp_reg <= stemp_next;
            odrop_reg <= miss_next;
            olink_reg <= link_next;
        end
    end

    assign out_valid  = ovld_reg;
    assign crc_ok     = ok_reg;
    assign frame_seq  = oseq_reg;
    assign temp_bits  = otemp_reg;
    assign drop_count = odrop_reg;
    assign link_up    = olink_reg;

endmodule

`default_nettype wire

// File: verif/tb_sensor_frame_deframer_crc16.sv
// tb_sensor_frame_deframer_crc16: self-checking bench for the sync-word deframer with crc16 check
// drives random serial bytes and valid or corrupted frames, predicts each frame result in a scoreboard
// depends on sfd_pkg and sensor_frame_deframer_crc16
`timescale 1ns / 1ps

module tb_sensor_frame_deframer_crc16;

    import sfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned PHASE_ITEMS = 425;

    typedef struct packed {
        logic        crc_ok;
        logic [7:0]  seq;
        logic [31:0] temp;
        logic [7:0]  drops;
        logic        link;
    } frame_result_t;

    // crc-16/ccitt-false, bit-serial form
    function automatic logic [15:0] ccitt_crc_next(input logic [15:0] crc_in,
                                                   input logic [7:0] data);
        logic [15:0] acc;
        logic        fb;
        acc = crc_in;
        for (int k = 7; k >= 0; k--)
        begin
            fb  = acc[15] ^ data[k];
            acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return acc;
    endfunction

    class frame_scoreboard;
        frame_result_t expected_q[$];
        int unsigned   errors;
        logic [7:0]    prev_byte;
        logic [2:0]    pos;
        logic          in_frame;
        logic [15:0]   crc_acc;
        logic [7:0]    seq;
        logic [31:0]   temp_acc;
        logic [15:0]   rx_crc;
        logic [7:0]    next_seq;
        logic [7:0]    drops;
        logic [31:0]   temp_kept;
        logic          link;

        function new();
            errors    = 0;
            prev_byte = 8'h00;
            pos       = 3'd0;
            in_frame  = 1'b0;
            crc_acc   = CRC_INIT;
            seq       = 8'h00;
            temp_acc  = 32'h0;
            rx_crc    = 16'h0;
            next_seq  = 8'h00;
            drops     = 8'h00;
            temp_kept = 32'h0;
            link      = 1'b0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_byte(input logic [7:0] b);
            frame_result_t r;
            if (!in_frame)
            begin
                if (prev_byte == SYNC_FIRST && b == SYNC_SECOND)
                begin
                    in_frame = 1'b1;
                    pos      = IDX_SEQ;
                    crc_acc  = CRC_INIT;
                    temp_acc = 32'h0;
                    rx_crc   = 16'h0;
                end
                else
                begin
                    prev_byte = b;
                end
                return;
            end
            if (pos < CRC_SPAN)
            begin
                crc_acc = ccitt_crc_next(crc_acc, b);
            end
            case (pos)
                IDX_SEQ:    seq             = b;
                IDX_TEMP0:  temp_acc[7:0]   = b;
                IDX_TEMP1:  temp_acc[15:8]  = b;
                IDX_TEMP2:  temp_acc[23:16] = b;
                IDX_TEMP3:  temp_acc[31:24] = b;
                IDX_CRC_LO: rx_crc[7:0]     = b;
                default:    rx_crc[15:8]    = b;
            endcase
            if (pos != IDX_CRC_HI)
            begin
                pos = pos + 3'd1;
                return;
            end
            r.crc_ok = (rx_crc == crc_acc);
            if (r.crc_ok)
            begin
                temp_kept = temp_acc;
                drops     = drops + (seq - next_seq);
                link      = 1'b1;
                next_seq  = seq + 8'd1;
            end
            in_frame  = 1'b0;
            pos       = IDX_SEQ;
            prev_byte = 8'h00;
            r.seq     = seq;
            r.temp    = temp_kept;
            r.drops   = drops;
            r.link    = link;
            expected_q.push_back(r);
        endfunction

        function void check_result(input frame_result_t got);
            frame_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected frame result, frame_seq %0h", got.seq);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.crc_ok !== want.crc_ok)
            begin
                $error("crc_ok expected %0h actual %0h", want.crc_ok, got.crc_ok);
                errors++;
            end
            if (got.seq !== want.seq)
            begin
                $error("frame_seq expected %0h actual %0h", want.seq, got.seq);
                errors++;
            end
            if (got.temp !== want.temp)
            begin
                $error("temp_bits expected %0h actual %0h", want.temp, got.temp);
                errors++;
            end
            if (got.drops !== want.drops)
            begin
                $error("drop_count expected %0h actual %0h", want.drops, got.drops);
                errors++;
            end
            if (got.link !== want.link)
            begin
                $error("link_up expected %0h actual %0h", want.link, got.link);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        crc_ok;
    logic [7:0]  frame_seq;
    logic [31:0] temp_bits;
    logic [7:0]  drop_count;
    logic        link_up;

    frame_scoreboard sb = new();
    int unsigned     cycle_count    = 0;
    int unsigned     bytes_sent     = 0;
    int unsigned     send_idle_pct  = 0;
    int unsigned     recv_stall_pct = 0;

    sensor_frame_deframer_crc16 i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .crc_ok     (crc_ok),
        .frame_seq  (frame_seq),
        .temp_bits  (temp_bits),
        .drop_count (drop_count),
        .link_up    (link_up)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL sensor_frame_deframer_crc16");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result({crc_ok, frame_seq, temp_bits, drop_count, link_up});
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] seq, input logic [31:0] temp, input bit corrupt);
        logic [15:0] crc;
        crc = ccitt_crc_next(CRC_INIT, seq);
        for (int i = 0; i < 4; i++)
        begin
            crc = ccitt_crc_next(crc, temp[8*i +: 8]);
        end
        if (corrupt)
        begin
            crc = crc ^ (16'h0001 << $urandom_range(15));
        end
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(seq);
        for (int i = 0; i < 4; i++)
        begin
            send_byte(temp[8*i +: 8]);
        end
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int unsigned kind;
        int unsigned n;
        logic [7:0]  seq_track;
        logic [7:0]  seq_pick;

        seq_track = 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // overlapping sync, extreme seq and temp, trailing 55, sync bytes in payload, bad crc
        send_byte(SYNC_FIRST);
        send_frame(8'hFF, 32'hFFFF_FFFF, 1'b0);
        send_byte(SYNC_SECOND);
        send_frame(8'h00, 32'h55AA_0000, 1'b1);
        send_frame(8'h00, 32'h0000_0000, 1'b0);
        drain_results();
        seq_track = 8'h01;

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            while (bytes_sent < (phase + 1) * PHASE_ITEMS)
            begin
                kind = $urandom_range(99);
                if (kind < 70)
                begin
                    seq_pick = ($urandom_range(3) == 0) ? 8'($urandom) : seq_track;
                    send_frame(seq_pick, $urandom, $urandom_range(4) == 0);
                    seq_track = seq_pick + 8'd1;
                end
                else if (kind < 80)
                begin
                    n = $urandom_range(1, 4);
                    repeat (n) send_byte(8'($urandom));
                end
                else if (kind < 86)
                begin
                    send_byte(SYNC_FIRST);
                    send_byte(8'($urandom));
                end
                else if (kind < 92)
                begin
                    // truncated frame whose tail swallows the start of the next one
                    send_byte(SYNC_FIRST);
                    send_byte(SYNC_SECOND);
                    n = $urandom_range(1, 6);
                    repeat (n) send_byte(8'($urandom));
                end
                else if (kind < 96)
                begin
                    send_byte(SYNC_FIRST);
                    send_frame(seq_track, $urandom, 1'b0);
                    seq_track = seq_track + 8'd1;
                end
                else
                begin
                    send_frame(seq_track, $urandom, 1'b0);
                    seq_track = seq_track + 8'd1;
                    send_byte(SYNC_SECOND);
                end
            end
            drain_results();
        end

        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("PASS sensor_frame_deframer_crc16");
        end
        else
        begin
            $display("FAIL sensor_frame_deframer_crc16");
        end
        $finish;
    end

endmodule
